// ----- rtl/pic_pkg.sv -----
// Package for the pedigree inbreeding coefficient core.
// Holds sizes, fixed-point constants, status codes and payload structs.
// No dependencies.
package pic_pkg;

  localparam int MAX_ANIMALS   = 4096;
  localparam int FRACTION_BITS = 30;
  localparam int IDX_W = $clog2(MAX_ANIMALS + 1);
  localparam int ADR_W = $clog2(MAX_ANIMALS);
  localparam int VAL_W = FRACTION_BITS + 1;
  localparam int CON_W = FRACTION_BITS + 2;
  localparam int SQ_W  = 2 * CON_W - FRACTION_BITS;
  localparam int ACC_W = FRACTION_BITS + 18;

  localparam logic [VAL_W-1:0] ONE         = VAL_W'(1) << FRACTION_BITS;
  localparam logic [IDX_W-1:0] IDX_UNKNOWN = IDX_W'(MAX_ANIMALS);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_PARENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] sire_index;
    logic [IDX_W-1:0] dam_index;
    logic [VAL_W-1:0] given_inbreeding;
  } pic_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] inbreeding;
    logic [VAL_W-1:0] sampling_variance;
    logic [1:0]       status;
  } pic_out_t;

  typedef struct packed {
    logic [IDX_W-1:0] sire;
    logic [IDX_W-1:0] dam;
  } pic_par_t;

endpackage

// ----- rtl/pedigree_inbreeding_coefficient_core.sv -----
// Top level of the pedigree inbreeding coefficient core.
// Depends on pic_pkg for sizes, constants and payload structs.
// Contains the stores, the ancestor-walk sequencer and its shared multiplier.

// Animals are sent in pedigree order, one transaction per animal: a transaction is
// accepted on a rising edge with start high and busy low, and exactly one result
// follows, shown for one cycle with out_strobe high; the receiver cannot stall it.
// After reset a clearing pass zeroes all MAX_ANIMALS entries of the contribution
// memory while busy is high. A store-full transaction answers in the following
// cycle. Otherwise S_LK0, S_LK1 and S_LK2 look up the parents' inbreeding, and in
// mode 0 or for a full sibling of the previous animal the result follows via S_FIN.
// In compute mode the ancestor walk scans every index from the animal down to 0
// through the contribution memory: each index passes S_RD, S_EV and S_NX, and a
// contributing entry also passes S_M1, S_AS, S_RDD, S_AD and S_CZ in between.
// The contribution memory has one read port and one write port, and one
// multiplier is shared by both products. The user writes compute_mode through
// cfg_we/cfg_data only while the block is idle; the block does not enforce this.
module pedigree_inbreeding_coefficient_core
  import pic_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pic_in_t  in_item,
  output logic     out_strobe,
  output pic_out_t out_result,
  input  logic     cfg_we,
  input  logic     cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_LK0  = 4'd2;
  localparam logic [3:0] S_LK1  = 4'd3;
  localparam logic [3:0] S_LK2  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_EV   = 4'd6;
  localparam logic [3:0] S_M1   = 4'd7;
  localparam logic [3:0] S_AS   = 4'd8;
  localparam logic [3:0] S_RDD  = 4'd9;
  localparam logic [3:0] S_AD   = 4'd10;
  localparam logic [3:0] S_CZ   = 4'd11;
  localparam logic [3:0] S_NX   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  localparam int TW = VAL_W + 2;

  // Stores. Parents, variance and inbreeding are written before they are read.
  pic_par_t         par_mem [MAX_ANIMALS];
  logic [VAL_W-1:0] var_mem [MAX_ANIMALS];
  logic [VAL_W-1:0] inf_mem [MAX_ANIMALS];
  logic [CON_W-1:0] con_mem [MAX_ANIMALS];

  logic [3:0]       state_r, state_nxt;
  logic             mode_r;
  logic [IDX_W-1:0] cnt_r;
  logic [ADR_W-1:0] clr_r;
  logic [IDX_W-1:0] s_r, d_r;
  logic [VAL_W-1:0] given_r, fs_r, dii_r, f_r, dv_r;
  logic [1:0]       status_r;
  logic [IDX_W-1:0] prev_s_r, prev_d_r;
  logic [VAL_W-1:0] prev_f_r;
  logic [ADR_W-1:0] j_r;
  logic [CON_W-1:0] li_r;
  logic [IDX_W-1:0] ps_r, pd_r;
  logic [SQ_W-1:0]  sq_r;
  logic [ACC_W-1:0] ai_r;
  logic             out_strobe_r;
  pic_out_t         out_r;

  // Memory read data, registered.
  pic_par_t         q_par;
  logic [VAL_W-1:0] q_var, q_inf;
  logic [CON_W-1:0] q_c;

  logic [ADR_W-1:0] rd_addr, c_raddr, c_waddr, k_addr;
  logic             c_we, par_we, inf_we;
  logic [CON_W-1:0] c_wdata;
  logic [TW-1:0]    t_sum;
  logic [VAL_W-1:0] dii_c, f_walk;
  logic [ACC_W-1:0] ai_m1;
  logic             s_unk, d_unk, accept;
  logic [IDX_W-1:0] s_eff, d_eff;
  logic [SQ_W-1:0]  mul_a;
  logic [CON_W-1:0] mul_b;
  logic [SQ_W+CON_W-1:0] mul_p;
  logic [CON_W-1:0] half;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign k_addr = cnt_r[ADR_W-1:0];
  assign half   = li_r >> 1;
  assign s_unk  = (s_r == IDX_UNKNOWN);
  assign d_unk  = (d_r == IDX_UNKNOWN);

  // A parent that is not earlier than this animal counts as unknown.
  always_comb begin
    s_eff = in_item.sire_index;
    d_eff = in_item.dam_index;
    if (in_item.sire_index != IDX_UNKNOWN && in_item.sire_index >= cnt_r) begin
      s_eff = IDX_UNKNOWN;
    end
    if (in_item.dam_index != IDX_UNKNOWN && in_item.dam_index >= cnt_r) begin
      d_eff = IDX_UNKNOWN;
    end
  end

  // dii = (2 - Fs - Fd) / 4 with an unknown parent counting as -1.
  always_comb begin
    t_sum = TW'(ONE) << 1;
    t_sum = s_unk ? t_sum + TW'(ONE) : t_sum - TW'(fs_r);
    t_sum = d_unk ? t_sum + TW'(ONE) : t_sum - TW'(q_inf);
    dii_c = t_sum[TW-1:2];
  end

  // One multiplier serves both products: li*li in S_M1, then the square
  // times the variance in S_AS.
  assign mul_a = (state_r == S_M1) ? SQ_W'(li_r) : sq_r;
  assign mul_b = (state_r == S_M1) ? li_r : CON_W'(dv_r);
  assign mul_p = mul_a * mul_b;
  assign ai_m1 = ai_r - ACC_W'(ONE);

  always_comb begin
    if (ai_r <= ACC_W'(ONE)) begin
      f_walk = '0;
    end else if (ai_m1 > ACC_W'(ONE)) begin
      f_walk = ONE;
    end else begin
      f_walk = ai_m1[VAL_W-1:0];
    end
  end

  // Address and write-enable selection for the stores.
  always_comb begin
    rd_addr = j_r;
    c_raddr = j_r;
    c_we    = 1'b0;
    c_waddr = j_r;
    c_wdata = '0;
    par_we  = 1'b0;
    inf_we  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        c_we    = 1'b1;
        c_waddr = clr_r;
      end
      S_LK0: rd_addr = s_r[ADR_W-1:0];
      S_LK1: rd_addr = d_r[ADR_W-1:0];
      S_LK2: begin
        par_we = 1'b1;
        if (mode_r && !(cnt_r != '0 && prev_s_r == s_r && prev_d_r == d_r)) begin
          c_we    = 1'b1;
          c_waddr = k_addr;
          c_wdata = CON_W'(ONE);
        end
      end
      S_M1: c_raddr = ps_r[ADR_W-1:0];
      S_AS: begin
        c_we    = (ps_r != IDX_UNKNOWN);
        c_waddr = ps_r[ADR_W-1:0];
        c_wdata = q_c + half;
      end
      S_RDD: c_raddr = pd_r[ADR_W-1:0];
      S_AD: begin
        c_we    = (pd_r != IDX_UNKNOWN);
        c_waddr = pd_r[ADR_W-1:0];
        c_wdata = q_c + half;
      end
      S_CZ: c_we = 1'b1;
      S_FIN: inf_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[k_addr] <= '{sire: s_r, dam: d_r};
      var_mem[k_addr] <= dii_c;
    end
    if (inf_we) begin
      inf_mem[k_addr] <= f_r;
    end
    if (c_we) begin
      con_mem[c_waddr] <= c_wdata;
    end
    q_par <= par_mem[rd_addr];
    q_var <= var_mem[rd_addr];
    q_inf <= inf_mem[rd_addr];
    q_c   <= con_mem[c_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && cnt_r != IDX_W'(MAX_ANIMALS)) state_nxt = S_LK0;
      S_CLR:  if (clr_r == ADR_W'(MAX_ANIMALS - 1)) state_nxt = S_IDLE;
      S_LK0:  state_nxt = S_LK1;
      S_LK1:  state_nxt = S_LK2;
      S_LK2: begin
        if (!mode_r || (cnt_r != '0 && prev_s_r == s_r && prev_d_r == d_r)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_EV;
      S_EV:  state_nxt = (q_c == '0) ? S_NX : S_M1;
      S_M1:  state_nxt = S_AS;
      S_AS:  state_nxt = S_RDD;
      S_RDD: state_nxt = S_AD;
      S_AD:  state_nxt = S_CZ;
      S_CZ:  state_nxt = S_NX;
      S_NX:  state_nxt = (j_r == '0) ? S_FIN : S_RD;
      S_FIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      mode_r       <= 1'b1;
      cnt_r        <= '0;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      if (state_r == S_CLR) begin
        clr_r <= clr_r + ADR_W'(1);
      end
      if (state_r == S_IDLE && accept && cnt_r == IDX_W'(MAX_ANIMALS)) begin
        out_strobe_r <= 1'b1;
      end
      if (state_r == S_FIN) begin
        out_strobe_r <= 1'b1;
        cnt_r        <= cnt_r + IDX_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        s_r      <= s_eff;
        d_r      <= d_eff;
        given_r  <= in_item.given_inbreeding;
        status_r <= (s_eff != in_item.sire_index || d_eff != in_item.dam_index)
                    ? ST_PARENT : ST_OK;
        if (accept && cnt_r == IDX_W'(MAX_ANIMALS)) begin
          out_r <= '{inbreeding: '0, sampling_variance: '0, status: ST_FULL};
        end
      end
      S_LK1: fs_r <= q_inf;
      S_LK2: begin
        dii_r <= dii_c;
        j_r   <= k_addr;
        ai_r  <= '0;
        if (!mode_r) begin
          f_r <= (given_r > ONE) ? ONE : given_r;
        end else begin
          f_r <= prev_f_r;
        end
      end
      S_EV: begin
        li_r <= q_c;
        ps_r <= q_par.sire;
        pd_r <= q_par.dam;
        dv_r <= q_var;
      end
      S_M1: sq_r <= mul_p[FRACTION_BITS +: SQ_W];
      S_AS: ai_r <= ai_r + ACC_W'(mul_p[SQ_W+CON_W-1:FRACTION_BITS]);
      S_NX: begin
        if (j_r == '0) begin
          f_r <= f_walk;
        end else begin
          j_r <= j_r - ADR_W'(1);
        end
      end
      S_FIN: begin
        prev_s_r <= s_r;
        prev_d_r <= d_r;
        prev_f_r <= f_r;
        out_r    <= '{inbreeding: f_r, sampling_variance: dii_r, status: status_r};
      end
      default: ;
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

  // A result only follows an accepted transaction or the S_FIN state.
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == S_FIN || $past(accept)))
    else $error("result strobe without a transaction");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.status == ST_FULL) |->
    (out_result.inbreeding == '0 && out_result.sampling_variance == '0))
    else $error("store-full result carries values");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IDX_W'(MAX_ANIMALS))
    else $error("animal count beyond store depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> $past(state_r) == S_FIN)
    else $error("animal count moved outside a stored transaction");

endmodule
